// ===== design/gaussian_smooth_3x3_rgb_macros.svh =====
// Assertion macros shared by the smoothing block.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef GAUSSIAN_SMOOTH_3X3_RGB_MACROS_SVH
`define GAUSSIAN_SMOOTH_3X3_RGB_MACROS_SVH

// Same-cycle implication.
`define GSS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gss: same-cycle check failed");

// Next-cycle implication.
`define GSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gss: next-cycle check failed");

`endif

// ===== design/gss_pkg.sv =====
package gss_pkg;

	localparam int GSS_MAX_WIDTH  = 2048;
	localparam int GSS_MAX_HEIGHT = 4096;

	localparam int CHAN_W     = 8;
	localparam int PIX_W      = 3 * CHAN_W;
	localparam int WIDTH_REG_W  = 12;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W = 13;
	localparam int COL_W      = 11;
	localparam int ROW_W      = 12;
	// one column of one channel: 1*t + 2*m + 1*b, at most 1020
	localparam int COLSUM_W   = 10;
	// three columns weighted 1-2-1, at most 4080
	localparam int TOTAL_W    = 12;
	localparam int GSS_QDEPTH = 4;
	localparam int QCNT_W     = $clog2(GSS_QDEPTH + 1);

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CHAN_W-1:0] chan_two;
		logic [CHAN_W-1:0] chan_one;
		logic [CHAN_W-1:0] chan_zero;
	} pix_t;

	typedef struct packed {
		logic [COL_W-1:0]  out_col;
		logic [ROW_W-1:0]  out_row;
		logic [CHAN_W-1:0] smooth_zero;
		logic [CHAN_W-1:0] smooth_one;
		logic [CHAN_W-1:0] smooth_two;
		logic              frame_end;
	} res_t;

	typedef logic [COLSUM_W-1:0] colsum_t;
	// one column sum for each channel, channel zero at index 0
	typedef colsum_t [2:0] colsums_t;

	typedef struct packed {
		colsums_t         left;
		colsums_t         centre;
		colsums_t         right;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
	} q_entry_t;

endpackage

// ===== design/gss_stream_if.sv =====
interface gss_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== design/gaussian_smooth_3x3_rgb.sv =====
// 3x3 Gaussian smoothing of a raster-order RGB pixel stream.
// Input channel pix: one pixel (three 8-bit channels) per request, row by row.
// Output channel res: one smoothed interior pixel with its column and row;
// frame_end marks the last interior pixel of the image. Border pixels give
// no result. Both channels move a request when valid and ready are high.
// Configuration: write image_width (index 0) and image_height (index 1)
// through cfg_we / cfg_index / cfg_data while the block is idle; sizes out of
// range are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT.
// Throughput: one pixel per clock while the queue has room, set by the line store
// doing one read and one write per cycle. A pixel that completes its window
// passes the s1 register and the queue before the output register holds its result.
// Reset: raster position returns to the image origin, size goes to 640x480,
// the window is cleared; the line stores are not cleared and need no pass.
// When res stalls, a four-entry queue and the output register absorb results;
// pix.ready drops once the queue cannot take the next one.
module gaussian_smooth_3x3_rgb import gss_pkg::*; #(
	parameter int MAX_WIDTH  = GSS_MAX_WIDTH,
	parameter int MAX_HEIGHT = GSS_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  reg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	gss_stream_if.sink            pix,
	gss_stream_if.source          res
);

	logic              push, pop, head_valid;
	q_entry_t          push_entry, head_entry;
	logic [QCNT_W-1:0] q_count;

	gss_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pix        (pix),
		.q_count    (q_count),
		.push       (push),
		.push_entry (push_entry)
	);

	gss_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.count      (q_count)
	);

	gss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.res        (res)
	);

endmodule

// ===== design/gss_front.sv =====
`include "gaussian_smooth_3x3_rgb_macros.svh"

module gss_front import gss_pkg::*; #(
	parameter int MAX_WIDTH  = GSS_MAX_WIDTH,
	parameter int MAX_HEIGHT = GSS_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  reg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	gss_stream_if.sink            pix,
	input  logic [QCNT_W-1:0]     q_count,
	output logic                  push,
	output q_entry_t              push_entry
);

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int YW  = $clog2(MAX_HEIGHT);
	localparam int WCW = (WIDTH_REG_W > $clog2(MAX_WIDTH + 1)) ?
		WIDTH_REG_W : $clog2(MAX_WIDTH + 1);
	localparam int HCW = (HEIGHT_REG_W > $clog2(MAX_HEIGHT + 1)) ?
		HEIGHT_REG_W : $clog2(MAX_HEIGHT + 1);

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [XW-1:0]           x_q;
	logic [YW-1:0]           y_q;

	logic [WCW-1:0] w_ext, w_eff, x_ext, xr, x_nx, x_d;
	logic [HCW-1:0] h_ext, h_eff, y_ext, y_inc, yr, y_nx, y_d;
	logic           wrap_x, end_row, accept, emit, last;

	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] line_rd_q;
	logic [PIX_W-1:0]   win_q [6];

	logic             valid_s1, emit_s1, last_s1;
	logic [XW-1:0]    x_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	pix_t             cur_s1;
	logic [PIX_W-1:0] up_px, mid_px;
	logic [QCNT_W:0]  q_need;

	function automatic colsums_t col_sum(logic [PIX_W-1:0] t, logic [PIX_W-1:0] m,
			logic [PIX_W-1:0] b);
		colsums_t s;
		for (int c = 0; c < 3; c++) begin
			s[c] = COLSUM_W'(t[c*CHAN_W +: CHAN_W]) + {1'b0, m[c*CHAN_W +: CHAN_W], 1'b0}
				+ COLSUM_W'(b[c*CHAN_W +: CHAN_W]);
		end
		return s;
	endfunction

	// take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default:    ;
			endcase
		end
	end

	// clamp the image size into the supported range
	always_comb begin
		w_ext = WCW'(width_q);
		h_ext = HCW'(height_q);
		w_eff = (w_ext < WCW'(3)) ? WCW'(3) :
			((w_ext > WCW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : w_ext);
		h_eff = (h_ext < HCW'(3)) ? HCW'(3) :
			((h_ext > HCW'(MAX_HEIGHT)) ? HCW'(MAX_HEIGHT) : h_ext);
	end

	// position of this pixel and of the next one
	always_comb begin
		x_ext   = WCW'(x_q);
		y_ext   = HCW'(y_q);
		wrap_x  = (x_ext >= w_eff);
		xr      = wrap_x ? '0 : x_ext;
		y_inc   = wrap_x ? y_ext + HCW'(1) : y_ext;
		yr      = (y_inc >= h_eff) ? '0 : y_inc;
		x_nx    = xr + WCW'(1);
		y_nx    = yr + HCW'(1);
		end_row = (x_nx >= w_eff);
		x_d     = end_row ? '0 : x_nx;
		y_d     = end_row ? ((y_nx >= h_eff) ? '0 : y_nx) : yr;
		emit    = (xr >= WCW'(2)) && (yr >= HCW'(2));
		last    = (xr == w_eff - WCW'(1)) && (yr == h_eff - HCW'(1));
	end

	// leave room in the queue for the item in flight and the new one
	assign q_need    = {1'b0, q_count} + (QCNT_W + 1)'(valid_s1 & emit_s1);
	assign pix.ready = (q_need < (QCNT_W + 1)'(GSS_QDEPTH));
	assign accept    = pix.valid & pix.ready;

	// advance the raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				x_q <= x_d[XW-1:0];
				y_q <= y_d[YW-1:0];
			end
		end
	end

	// hold the accepted pixel until the next one is accepted
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1  <= pix.payload;
			x_s1    <= xr[XW-1:0];
			emit_s1 <= emit;
			last_s1 <= last;
			col_s1  <= COL_W'(xr - WCW'(1));
			row_s1  <= ROW_W'(yr - HCW'(1));
		end
	end

	// line store read: rows y-2 and y-1 of this column
	always_ff @(posedge clk) begin
		if (accept) begin
			line_rd_q <= line_mem[xr[XW-1:0]];
		end
	end

	assign up_px  = line_rd_q[2*PIX_W-1:PIX_W];
	assign mid_px = line_rd_q[PIX_W-1:0];

	// line store write: shift the column up by one row
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			line_mem[x_s1] <= {mid_px, cur_s1};
		end
	end

	// shift the window one column left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (valid_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= up_px;
			win_q[4] <= mid_px;
			win_q[5] <= cur_s1;
		end
	end

	// request to the queue with the three column sums
	assign push              = valid_s1 & emit_s1;
	assign push_entry.left   = col_sum(win_q[0], win_q[1], win_q[2]);
	assign push_entry.centre = col_sum(win_q[3], win_q[4], win_q[5]);
	assign push_entry.right  = col_sum(up_px, mid_px, cur_s1);
	assign push_entry.col    = col_s1;
	assign push_entry.row    = row_s1;
	assign push_entry.last   = last_s1;

	`GSS_ASSERT_NOW(a_push_has_room, push, q_count < QCNT_W'(GSS_QDEPTH))
	`GSS_ASSERT_NEXT(a_accept_enters_s1, accept, valid_s1)

endmodule

// ===== design/gss_fifo.sv =====
`include "gaussian_smooth_3x3_rgb_macros.svh"

module gss_fifo import gss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  q_entry_t          push_entry,
	input  logic              pop,
	output logic              head_valid,
	output q_entry_t          head_entry,
	output logic [QCNT_W-1:0] count
);

	localparam int PW = (GSS_QDEPTH > 1) ? $clog2(GSS_QDEPTH) : 1;

	q_entry_t          mem_q [GSS_QDEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
		return (p == PW'(GSS_QDEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	// store the request
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// move pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign count      = count_q;

	`GSS_ASSERT_NOW(a_no_overflow, push && !pop, count_q < QCNT_W'(GSS_QDEPTH))
	`GSS_ASSERT_NOW(a_no_underflow, pop, count_q != '0)
	`GSS_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + QCNT_W'(1))

endmodule

// ===== design/gss_back.sv =====
`include "gaussian_smooth_3x3_rgb_macros.svh"

module gss_back import gss_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         head_valid,
	input  q_entry_t     head_entry,
	output logic         pop,
	gss_stream_if.source res
);

	res_t res_q;
	logic res_valid_q;
	logic [TOTAL_W-1:0] total [3];

	// weight the columns 1-2-1; the sum stays below 4096, so /16 fits 8 bits
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			total[c] = TOTAL_W'(head_entry.left[c]) + {1'b0, head_entry.centre[c], 1'b0}
				+ TOTAL_W'(head_entry.right[c]);
		end
	end

	assign pop = head_valid && (!res_valid_q || res.ready);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || res.ready) begin
			res_valid_q <= head_valid;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.out_col     <= head_entry.col;
			res_q.out_row     <= head_entry.row;
			res_q.smooth_zero <= total[0][TOTAL_W-1:4];
			res_q.smooth_one  <= total[1][TOTAL_W-1:4];
			res_q.smooth_two  <= total[2][TOTAL_W-1:4];
			res_q.frame_end   <= head_entry.last;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

	`GSS_ASSERT_NEXT(a_pop_loads_output, pop, res_valid_q)

endmodule
